### hdl/sekt_pkg.sv
// Shared types and constants for the SIEVE eviction key table.
`default_nettype none
package sekt_pkg;
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 64;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;

    typedef struct packed {
        logic load;
        logic search;
        logic lookup_hit;
        logic delete_hit;
        logic walk_step;
        logic evict;
        logic insert;
    } sekt_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic hit;
        logic need_evict;
        logic hand_visited;
    } sekt_status_t;
endpackage
`default_nettype wire

### hdl/sekt_datapath.sv
// Datapath of the SIEVE key table: entry storage, links, hand and result register.
`default_nettype none
module sekt_datapath (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire sekt_pkg::sekt_cmd_t cmd,
    output sekt_pkg::sekt_status_t   status,
    input  wire [1:0]                in_kind,
    input  wire [63:0]               in_key,
    input  wire [4:0]                max_entries,
    output logic                     found,
    output logic [3:0]               slot,
    output logic                     evicted,
    output logic [63:0]              evicted_key
);
    import sekt_pkg::*;

    logic [KEY_BITS-1:0] key_mem [CAPACITY];
    logic [SLOT_W-1:0]   newer_mem [CAPACITY];
    logic [SLOT_W-1:0]   older_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] visited_reg;
    logic [SLOT_W-1:0]   newest_reg, oldest_reg, hand_reg, hit_slot_reg, free_slot_reg;
    logic                hand_valid_reg, hit_reg, free_found_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [1:0]          kind_reg;
    logic [KEY_BITS-1:0] key_reg;

    logic [SLOT_W-1:0]   hit_idx, free_idx, cur, nxt_of_cur;
    logic                hit_any, free_any;
    logic [CNT_W-1:0]    limit;

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_mem[i] == key_reg)
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        if (max_entries == 5'd0)
            limit = CNT_W'(1);
        else if ({1'b0, max_entries} > 6'(CAPACITY))
            limit = CNT_W'(CAPACITY);
        else
            limit = CNT_W'(max_entries);
    end

    assign cur = hand_valid_reg ? hand_reg : oldest_reg;
    assign nxt_of_cur = (cur == newest_reg) ? oldest_reg : newer_mem[cur];

    assign status.kind = kind_reg;
    assign status.hit = hit_reg;
    assign status.need_evict = (count_reg >= limit) && (count_reg != '0);
    assign status.hand_visited = visited_reg[cur];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            key_reg <= in_key[KEY_BITS-1:0];
        end
        if (cmd.search)
        begin
            hit_slot_reg <= hit_idx;
        end
        if (cmd.insert && free_found_reg)
        begin
            key_mem[free_slot_reg] <= key_reg;
            if (count_reg != '0)
            begin
                newer_mem[newest_reg] <= free_slot_reg;
                older_mem[free_slot_reg] <= newest_reg;
            end
        end
        if (cmd.delete_hit && count_reg > CNT_W'(1) && hit_slot_reg != newest_reg
            && hit_slot_reg != oldest_reg)
        begin
            newer_mem[older_mem[hit_slot_reg]] <= newer_mem[hit_slot_reg];
            older_mem[newer_mem[hit_slot_reg]] <= older_mem[hit_slot_reg];
        end
        if (cmd.evict && count_reg > CNT_W'(1) && cur != newest_reg && cur != oldest_reg)
        begin
            newer_mem[older_mem[cur]] <= newer_mem[cur];
            older_mem[newer_mem[cur]] <= older_mem[cur];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            visited_reg <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            hand_reg <= '0;
            hand_valid_reg <= 1'b0;
            count_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            free_slot_reg <= '0;
            found <= 1'b0;
            slot <= '0;
            evicted <= 1'b0;
            evicted_key <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                found <= 1'b0;
                slot <= '0;
                evicted <= 1'b0;
                evicted_key <= '0;
            end
            if (cmd.search)
            begin
                hit_reg <= hit_any && (kind_reg != KIND_UNKNOWN);
                found <= hit_any && (kind_reg != KIND_UNKNOWN);
                if (hit_any && (kind_reg == KIND_LOOKUP || kind_reg == KIND_INSERT))
                    slot <= 4'(hit_idx);
            end
            if (cmd.lookup_hit)
                visited_reg[hit_slot_reg] <= 1'b1;
            if (cmd.delete_hit)
            begin
                if (hand_valid_reg && hand_reg == hit_slot_reg)
                begin
                    if (hit_slot_reg == newest_reg)
                        hand_valid_reg <= 1'b0;
                    else
                        hand_reg <= newer_mem[hit_slot_reg];
                end
                if (count_reg > CNT_W'(1))
                begin
                    if (hit_slot_reg == newest_reg)
                        newest_reg <= older_mem[hit_slot_reg];
                    else if (hit_slot_reg == oldest_reg)
                        oldest_reg <= newer_mem[hit_slot_reg];
                end
                valid_reg[hit_slot_reg] <= 1'b0;
                visited_reg[hit_slot_reg] <= 1'b0;
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.walk_step)
            begin
                visited_reg[cur] <= 1'b0;
                hand_reg <= nxt_of_cur;
                hand_valid_reg <= 1'b1;
            end
            if (cmd.evict)
            begin
                evicted <= 1'b1;
                evicted_key <= 64'(key_mem[cur]);
                if (count_reg <= CNT_W'(1))
                    hand_valid_reg <= 1'b0;
                else
                begin
                    hand_reg <= nxt_of_cur;
                    hand_valid_reg <= 1'b1;
                    if (cur == newest_reg)
                        newest_reg <= older_mem[cur];
                    else if (cur == oldest_reg)
                        oldest_reg <= newer_mem[cur];
                end
                valid_reg[cur] <= 1'b0;
                visited_reg[cur] <= 1'b0;
                count_reg <= count_reg - CNT_W'(1);
            end
            if (!cmd.evict && !cmd.walk_step)
            begin
                free_found_reg <= free_any;
                free_slot_reg <= free_idx;
            end
            if (cmd.insert && free_found_reg)
            begin
                valid_reg[free_slot_reg] <= 1'b1;
                visited_reg[free_slot_reg] <= 1'b0;
                if (count_reg == '0)
                    oldest_reg <= free_slot_reg;
                newest_reg <= free_slot_reg;
                count_reg <= count_reg + CNT_W'(1);
                slot <= 4'(free_slot_reg);
            end
        end
    end
endmodule
`default_nettype wire

### hdl/sekt_control.sv
// Controller state machine of the SIEVE key table.
`default_nettype none
module sekt_control (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    input  wire sekt_pkg::sekt_status_t status,
    output sekt_pkg::sekt_cmd_t         cmd
);
    import sekt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_ACT = 3'd2;
    localparam logic [2:0] ST_EVICT = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_INSERT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       done;

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (status.kind == KIND_LOOKUP && status.hit)
                begin
                    cmd.lookup_hit = 1'b1;
                    done = 1'b1;
                end
                else if (status.kind == KIND_DELETE && status.hit)
                begin
                    cmd.delete_hit = 1'b1;
                    done = 1'b1;
                end
                else if (status.kind == KIND_INSERT && !status.hit)
                    state_next = ST_EVICT;
                else
                    done = 1'b1;
            end
            ST_EVICT:
            begin
                if (!status.need_evict)
                    state_next = ST_SCAN;
                else if (status.hand_visited)
                    cmd.walk_step = 1'b1;
                else
                    cmd.evict = 1'b1;
            end
            ST_SCAN:
                state_next = ST_INSERT;
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                done = 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (done)
            state_next = ST_IDLE;
        out_valid_next = done ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

### hdl/sieve_eviction_key_table_unit.sv
// Top level of the SIEVE eviction key table with APB configuration.
// Sequence: lookup, delete and present-key insert pass through the search and act states;
// an absent-key insert then goes through evict (clearing visited entries and taking
// victims as needed), scan and insert.
// One item at a time: next input accepted the cycle after the result is taken.
// Reset: valid bits, visited bits, count and hand clear; max_entries is 16.
`default_nettype none
module sieve_eviction_key_table_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,   // key[63:0]
    input  wire [1:0]   s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // found[0], slot[4:1], evicted[5], evicted_key[69:6], pad
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [1:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sekt_pkg::*;

    sekt_cmd_t    cmd;
    sekt_status_t status;
    logic [4:0]   max_entries_reg;
    logic         found;
    logic [3:0]   slot;
    logic         evicted;
    logic [63:0]  evicted_key;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_ENTRIES) ? {27'd0, max_entries_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_entries_reg <= 5'd16;
        else if (psel && penable && pwrite && paddr == REG_MAX_ENTRIES)
            max_entries_reg <= pwdata[4:0];
    end

    assign m_tdata = {2'b00, evicted_key, evicted, slot, found};

    sekt_control u_control (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .status(status), .cmd(cmd)
    );

    sekt_datapath u_datapath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_kind(s_tuser), .in_key(s_tdata),
        .max_entries(max_entries_reg), .found(found), .slot(slot),
        .evicted(evicted), .evicted_key(evicted_key)
    );
endmodule
`default_nettype wire
